/* design/olar_pkg.sv */
`default_nettype none

package olar_pkg;

    localparam int LIST_DEPTH_DEFAULT = 16;
    localparam int VALUE_W = 32;
    localparam int COUNT_OUT_W = 5;

    localparam logic KIND_APPEND = 1'b0;
    localparam logic KIND_REMOVE = 1'b1;

    typedef struct packed {
        logic                      kind;
        logic signed [VALUE_W-1:0] value;
    } in_t;

    typedef struct packed {
        logic                   matched;
        logic                   overflow;
        logic [COUNT_OUT_W-1:0] entry_count;
    } out_t;

    // Per-beat control broadcast to every cell of the row.
    typedef struct packed {
        logic load;
        logic remove;
    } cell_ctl_t;

endpackage

`default_nettype wire

/* design/ordered_list_append_remove_unit.sv */
`default_nettype none

// Channel | Direction | Handshake          | Beat
// --------+-----------+--------------------+----------------------------
// in      | input     | in_valid/in_ready  | in_data  (kind, value)
// out     | output    | out_valid/out_ready| out_data (matched, overflow,
//         |           |                    |           entry_count)
//
// One beat is taken per cycle while in_ready is high: every cell compares
// against the key at once, and the match ripples down the row of cells so the
// list compacts in the same cycle. The result appears the cycle after the beat.
// in_ready stays high while the output register is empty or being drained.
// rst_n clears the fill count and the output valid; cell contents are not reset.
module ordered_list_append_remove_unit #(
    parameter int LIST_DEPTH = olar_pkg::LIST_DEPTH_DEFAULT
) (
    input  wire            clk,
    input  wire            rst_n,
    input  wire            in_valid,
    output logic           in_ready,
    input  olar_pkg::in_t  in_data,
    output logic           out_valid,
    input  wire            out_ready,
    output olar_pkg::out_t out_data
);
    import olar_pkg::*;

    localparam int CNT_W = $clog2(LIST_DEPTH + 1);
    localparam logic [CNT_W-1:0] FULL_COUNT = CNT_W'(LIST_DEPTH);

    logic [CNT_W-1:0]          count_reg;
    logic [CNT_W-1:0]          count_next;
    logic                      out_valid_reg;
    logic                      out_valid_next;
    out_t                      out_data_reg;
    out_t                      out_data_next;
    logic                      accept;
    logic                      full;
    logic                      is_remove;
    cell_ctl_t                 ctl;
    logic                      hits [LIST_DEPTH+1];
    logic signed [VALUE_W-1:0] values [LIST_DEPTH+1];
    logic [CNT_W+COUNT_OUT_W-1:0] count_wide;

    assign in_ready   = !out_valid_reg || out_ready;
    assign accept     = in_valid && in_ready;
    assign full       = count_reg == FULL_COUNT;
    assign is_remove  = in_data.kind == KIND_REMOVE;
    assign ctl.load   = accept;
    assign ctl.remove = is_remove;
    assign hits[0]    = 1'b0;
    // The last cell never needs a real neighbor: after a removal it drops
    // out of the occupied range.
    assign values[LIST_DEPTH] = values[LIST_DEPTH-1];

    genvar g;
    generate
        for (g = 0; g < LIST_DEPTH; g++)
        begin : g_cell
            olar_cell #(
                .LIST_DEPTH (LIST_DEPTH),
                .INDEX      (g),
                .CNT_W      (CNT_W)
            ) u_cell (
                .clk        (clk),
                .ctl        (ctl),
                .count      (count_reg),
                .key        (in_data.value),
                .hit_in     (hits[g]),
                .next_value (values[g+1]),
                .hit_out    (hits[g+1]),
                .value      (values[g])
            );
        end
    endgenerate

    always_comb
    begin
        count_next     = count_reg;
        out_valid_next = out_valid_reg && !out_ready;
        out_data_next  = out_data_reg;
        if (accept)
        begin
            out_valid_next = 1'b1;
            out_data_next.matched  = 1'b0;
            out_data_next.overflow = 1'b0;
            if (is_remove)
            begin
                if (hits[LIST_DEPTH])
                begin
                    count_next = count_reg - 1'b1;
                    out_data_next.matched = 1'b1;
                end
            end
            else if (full)
            begin
                out_data_next.overflow = 1'b1;
            end
            else
            begin
                count_next = count_reg + 1'b1;
            end
        end
        count_wide = {{COUNT_OUT_W{1'b0}}, count_next};
        if (accept)
        begin
            out_data_next.entry_count = count_wide[COUNT_OUT_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_data_reg <= out_data_next;
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= FULL_COUNT)
        else $error("fill count exceeds list depth");

    a_flags_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> !(out_data_reg.matched && out_data_reg.overflow))
        else $error("matched and overflow both set");

    a_append_grows: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && !is_remove && !full) |=> count_reg == $past(count_reg) + 1'b1)
        else $error("append did not grow the list");

    a_remove_miss_keeps: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && is_remove && !hits[LIST_DEPTH]) |=> $stable(count_reg))
        else $error("missed remove changed the count");

    a_result_follows_beat: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(accept))
        else $error("result without an input beat");

endmodule

`default_nettype wire

/* design/olar_cell.sv */
`default_nettype none

module olar_cell #(
    parameter int LIST_DEPTH = olar_pkg::LIST_DEPTH_DEFAULT,
    parameter int INDEX = 0,
    parameter int CNT_W = $clog2(LIST_DEPTH + 1)
) (
    input  wire                                 clk,
    input  olar_pkg::cell_ctl_t                 ctl,
    input  wire [CNT_W-1:0]                     count,
    input  wire signed [olar_pkg::VALUE_W-1:0]  key,
    input  wire                                 hit_in,
    input  wire signed [olar_pkg::VALUE_W-1:0]  next_value,
    output logic                                hit_out,
    output logic signed [olar_pkg::VALUE_W-1:0] value
);
    import olar_pkg::*;

    localparam logic [CNT_W-1:0] MY_INDEX = CNT_W'(INDEX);

    logic signed [VALUE_W-1:0] value_reg;
    logic signed [VALUE_W-1:0] value_next;
    logic                      occupied;
    logic                      hit_here;

    assign occupied = MY_INDEX < count;
    assign hit_here = occupied && (value_reg == key);
    // Once a match has been seen at or before this cell, every cell from
    // here on pulls its neighbor's value on a remove to close the gap.
    assign hit_out  = hit_in | hit_here;
    assign value    = value_reg;

    always_comb
    begin
        value_next = value_reg;
        if (ctl.load)
        begin
            if (ctl.remove)
            begin
                if (hit_out)
                begin
                    value_next = next_value;
                end
            end
            else if (MY_INDEX == count)
            begin
                value_next = key;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        value_reg <= value_next;
    end

endmodule

`default_nettype wire

/* tb/ordered_list_append_remove_unit_tb.sv */
`timescale 1ns / 100ps

module ordered_list_append_remove_unit_tb;

    import olar_pkg::*;

    localparam int LIST_DEPTH   = 16;
    localparam int RANDOM_ITEMS = 1750;
    localparam int BLOCK_ITEMS  = 125;
    localparam int CYCLE_LIMIT  = 400000;
    localparam int DRAIN_CYCLES = 20;

    typedef struct packed {
        logic        kind;
        logic [31:0] value;
        logic        typed;
        out_t        result;
    } row_t;

    logic clk;
    logic rst_n;
    logic in_valid;
    logic in_ready;
    in_t  in_data;
    logic out_valid;
    logic out_ready;
    out_t out_data;

    // Shadow of the list contents, head at index 0.
    logic [31:0] list_vals [LIST_DEPTH];
    int          list_len;

    out_t        pending_results [$];
    row_t        directed_rows [$];

    int          cycle_count;
    int          mismatch_count;
    int          beats_checked;
    int          appends_sent;
    int          removes_sent;
    int          hits_seen;
    int          drops_seen;
    bit          no_idle;

    ordered_list_append_remove_unit #(
        .LIST_DEPTH(LIST_DEPTH)
    ) u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic row_t make_row(logic kind, logic [31:0] value, logic typed,
                                      logic matched, logic overflow, int count);
        row_t r;
        r.kind                 = kind;
        r.value                = value;
        r.typed                = typed;
        r.result.matched       = matched;
        r.result.overflow      = overflow;
        r.result.entry_count   = count[COUNT_OUT_W-1:0];
        return r;
    endfunction

    task automatic apply_to_list(input in_t item, output out_t res);
        int  i;
        int  j;
        bit  hit;
        hit = 1'b0;
        res = '0;
        if (item.kind == KIND_APPEND)
        begin
            appends_sent++;
            if (list_len < LIST_DEPTH)
            begin
                list_vals[list_len] = item.value;
                list_len++;
            end
            else
            begin
                res.overflow = 1'b1;
                drops_seen++;
            end
        end
        else
        begin
            removes_sent++;
            for (i = 0; i < list_len && !hit; i++)
            begin
                if (list_vals[i] == item.value)
                begin
                    for (j = i; j + 1 < list_len; j++)
                        list_vals[j] = list_vals[j + 1];
                    list_len--;
                    hit = 1'b1;
                end
            end
            res.matched = hit;
            if (hit)
                hits_seen++;
        end
        res.entry_count = list_len[COUNT_OUT_W-1:0];
    endtask

    function automatic logic [31:0] pick_value();
        logic [31:0] v;
        case ($urandom_range(0, 9))
            0:       v = 32'h8000_0000;
            1:       v = 32'h7FFF_FFFF;
            2, 3, 4: v = 32'($urandom_range(0, 7)) - 32'd4;
            default: v = $urandom;
        endcase
        return v;
    endfunction

    // Drives one input beat after a random gap and records its prediction on acceptance.
    task automatic send_beat(input in_t item, input logic typed, input out_t typed_res);
        int   gap;
        out_t res;
        gap = no_idle ? 0 : $urandom_range(0, 15);
        repeat (gap)
        begin
            @(negedge clk);
            in_valid <= 1'b0;
        end
        @(negedge clk);
        in_valid <= 1'b1;
        in_data  <= item;
        do
            @(posedge clk);
        while (!in_ready);
        apply_to_list(item, res);
        pending_results.push_back(typed ? typed_res : res);
    endtask

    // Receiver: random stall before each result beat, none while no_idle is set.
    initial
    begin
        int stall;
        out_ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            stall = no_idle ? 0 : $urandom_range(0, 15);
            repeat (stall)
            begin
                @(negedge clk);
                out_ready <= 1'b0;
            end
            @(negedge clk);
            out_ready <= 1'b1;
            do
                @(posedge clk);
            while (!out_valid);
        end
    end

    always @(posedge clk)
    begin
        out_t want;
        if (rst_n && out_valid && out_ready)
        begin
            beats_checked++;
            if (pending_results.size() == 0)
            begin
                mismatch_count++;
                if (mismatch_count <= 10)
                    $display("ERROR: result beat with nothing pending: %p", out_data);
            end
            else
            begin
                want = pending_results.pop_front();
                if (out_data.matched !== want.matched
                    || out_data.overflow !== want.overflow
                    || out_data.entry_count !== want.entry_count)
                begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("ERROR: beat %0d expected m=%0b o=%0b n=%0d, got m=%0b o=%0b n=%0d",
                                 beats_checked, want.matched, want.overflow, want.entry_count,
                                 out_data.matched, out_data.overflow, out_data.entry_count);
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("Timeout after %0d cycles", cycle_count);
            $display("FAIL ordered_list_append_remove_unit");
            $finish;
        end
    end

    initial
    begin
        in_t         item;
        row_t        r;
        int          k;
        int          append_pct;
        logic [31:0] fill_vals [12];

        rst_n          = 1'b0;
        in_valid       = 1'b0;
        in_data        = '0;
        cycle_count    = 0;
        mismatch_count = 0;
        beats_checked  = 0;
        appends_sent   = 0;
        removes_sent   = 0;
        hits_seen      = 0;
        drops_seen     = 0;
        no_idle        = 1'b0;
        list_len       = 0;
        for (k = 0; k < LIST_DEPTH; k++)
            list_vals[k] = '0;

        fill_vals = '{32'h0000_0001, 32'hFFFF_FFFE, 32'hA5A5_A5A5, 32'h5A5A_5A5A,
                      32'h0000_FFFF, 32'hFFFF_0000, 32'h1234_5678, 32'h8765_4321,
                      32'h0000_0000, 32'hDEAD_BEEF, 32'h7FFF_FFFE, 32'h8000_0001};

        // Empty list, extremes, duplicate, near miss, fill to full, overflow, removes.
        directed_rows.push_back(make_row(KIND_REMOVE, 32'd5,         1'b1, 1'b0, 1'b0, 0));
        directed_rows.push_back(make_row(KIND_APPEND, 32'h8000_0000, 1'b1, 1'b0, 1'b0, 1));
        directed_rows.push_back(make_row(KIND_APPEND, 32'h7FFF_FFFF, 1'b1, 1'b0, 1'b0, 2));
        directed_rows.push_back(make_row(KIND_APPEND, 32'hFFFF_FFFF, 1'b1, 1'b0, 1'b0, 3));
        directed_rows.push_back(make_row(KIND_APPEND, 32'h0000_0000, 1'b1, 1'b0, 1'b0, 4));
        directed_rows.push_back(make_row(KIND_APPEND, 32'h7FFF_FFFF, 1'b0, 1'b0, 1'b0, 0));
        directed_rows.push_back(make_row(KIND_REMOVE, 32'h7FFF_FFFF, 1'b0, 1'b0, 1'b0, 0));
        directed_rows.push_back(make_row(KIND_REMOVE, 32'h7FFF_FFFE, 1'b0, 1'b0, 1'b0, 0));
        for (k = 0; k < 12; k++)
            directed_rows.push_back(make_row(KIND_APPEND, fill_vals[k], 1'b0, 1'b0, 1'b0, 0));
        directed_rows.push_back(make_row(KIND_APPEND, 32'h1111_1111, 1'b1, 1'b0, 1'b1, 16));
        directed_rows.push_back(make_row(KIND_REMOVE, 32'h8000_0000, 1'b0, 1'b0, 1'b0, 0));
        directed_rows.push_back(make_row(KIND_REMOVE, 32'h0000_0000, 1'b0, 1'b0, 1'b0, 0));
        directed_rows.push_back(make_row(KIND_REMOVE, 32'hFFFF_FFFF, 1'b0, 1'b0, 1'b0, 0));

        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        foreach (directed_rows[i])
        begin
            r = directed_rows[i];
            item.kind  = r.kind;
            item.value = r.value;
            send_beat(item, r.typed, r.result);
        end

        // Most blocks lean toward appends or removes so the list swings between
        // empty and full; every fifth block runs with no idle cycles at all.
        for (k = 0; k < RANDOM_ITEMS; k++)
        begin
            if (k % BLOCK_ITEMS == 0)
            begin
                case ((k / BLOCK_ITEMS) % 4)
                    0:       append_pct = 85;
                    1:       append_pct = 50;
                    2:       append_pct = 15;
                    default: append_pct = 65;
                endcase
                no_idle = ((k / BLOCK_ITEMS) % 5 == 3);
            end
            if ($urandom_range(0, 99) < append_pct)
            begin
                item.kind  = KIND_APPEND;
                item.value = pick_value();
            end
            else
            begin
                item.kind = KIND_REMOVE;
                if (list_len > 0 && $urandom_range(0, 99) < 65)
                    item.value = list_vals[$urandom_range(0, list_len - 1)];
                else
                    item.value = pick_value();
            end
            send_beat(item, 1'b0, '0);
        end

        @(negedge clk);
        in_valid <= 1'b0;

        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Covered %0d appends (%0d dropped on a full list) and %0d removes (%0d hits).",
                 appends_sent, drops_seen, removes_sent, hits_seen);
        $display("Checked %0d result beats, %0d mismatches, %0d cycles.",
                 beats_checked, mismatch_count, cycle_count);
        if (mismatch_count == 0)
            $display("PASS ordered_list_append_remove_unit");
        else
            $display("FAIL ordered_list_append_remove_unit");
        $finish;
    end

endmodule

/* filelist.f */
design/olar_pkg.sv
design/olar_cell.sv
design/ordered_list_append_remove_unit.sv
tb/ordered_list_append_remove_unit_tb.sv
